// File: hdl/rnd_pkg.sv
// Shared types, constants and table lookup for the rANS nibble decoder.
package rnd_pkg;

	localparam int unsigned LowerBoundLog2 = 23;
	localparam int unsigned MaxSymbols     = 16;
	localparam logic [31:0] StateBound     = 32'd1 << LowerBoundLog2;

	// Configuration register indexes
	localparam logic [2:0] REG_TOTAL_FREQ    = 3'd0;
	localparam logic [2:0] REG_ALPHABET_SIZE = 3'd1;
	localparam logic [2:0] REG_CUM_LOW       = 3'd2;
	localparam logic [2:0] REG_CUM_MID       = 3'd3;
	localparam logic [2:0] REG_CUM_HIGH      = 3'd4;
	localparam logic [2:0] REG_SYMBOL_COUNT  = 3'd5;

	// Operation codes
	localparam logic OP_START  = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DIV    = 7'b0000010,
		ST_SEARCH = 7'b0000100,
		ST_MUL    = 7'b0001000,
		ST_ADD    = 7'b0010000,
		ST_RENORM = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [3:0] symbol;
		logic [2:0] bytes_used;
		logic [7:0] packed_byte;
		logic       byte_valid;
		logic       finished;
	} result_t;

	// Cumulative start of symbol s; symbol 0 starts at 0.
	function automatic logic [11:0] cum_start(input logic [59:0] tab_lo,
		input logic [59:0] tab_mid, input logic [59:0] tab_hi, input logic [3:0] s);
		logic [11:0] r;
		r = 12'd0;
		if (s == 4'd0) begin
			r = 12'd0;
		end else if (s <= 4'd5) begin
			r = tab_lo[(int'(s) - 1) * 12 +: 12];
		end else if (s <= 4'd10) begin
			r = tab_mid[(int'(s) - 6) * 12 +: 12];
		end else begin
			r = tab_hi[(int'(s) - 11) * 12 +: 12];
		end
		return r;
	endfunction

endpackage

// File: hdl/rnd_div.sv
// Restoring radix-2 divider: 32-bit dividend by 13-bit divisor, one bit per cycle.
module rnd_div import rnd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [12:0] divisor,
	output logic        done,
	output logic [31:0] quotient,
	output logic [12:0] remainder
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [12:0] rem_q;
	logic [31:0] quo_q;
	logic [12:0] div_q;

	logic [13:0] trial;
	logic        fits;
	logic [13:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[12:0] : trial[12:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: hdl/rans_nibble_decoder_unit.sv
// Top level of the rANS nibble decoder: control sequencer, coder state and result register.
//
// Range-ANS decoder for 4-bit symbols with a 32-bit state and backward byte-wise
// renormalization. A start transaction (operation 0) loads the state from stream_word
// and reports the bytes it took; a decode transaction (operation 1) yields one symbol,
// the stream bytes it shifted in (at most three, taken from stream_word high byte
// first) and, on every second symbol or the last one, a packed byte. Once symbol_count
// symbols are decoded, further decode transactions only report finished. The input
// takes one transaction at a time: in_stall stays high while an item is in work. A
// start item, or a decode after the end, goes from acceptance straight to the done
// state, which moves its result to the output register once that is free; the next
// transaction is accepted when the sequencer is back in idle. A decode first passes
// through the divide, search, multiply, add and renormalize states. The state modulo
// and quotient by total_freq come from a single one-bit-per-cycle restoring divider,
// the cumulative table is scanned one entry per cycle, then one multiply, one add and
// one renormalization byte per cycle follow, and the done state moves the result to
// the output register once it is free. The result sits in an output register, so the
// next transaction is accepted while a finished result still waits under out_stall.
// Configuration writes are always taken (cfg_ready is high) and must only be issued
// while the block is idle; indexes beyond the register list are ignored.
module rans_nibble_decoder_unit import rnd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [59:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [31:0] stream_word,
	input  logic [2:0]  bytes_left,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  symbol,
	output logic [2:0]  bytes_used,
	output logic [7:0]  packed_byte,
	output logic        byte_valid,
	output logic        finished
);

	// Configuration registers
	logic [12:0] total_freq_q;
	logic [4:0]  alphabet_size_q;
	logic [59:0] cum_low_q;
	logic [59:0] cum_mid_q;
	logic [59:0] cum_high_q;
	logic [15:0] symbol_count_q;

	// Decoder state
	logic [31:0] coder_state_q;
	logic [15:0] symbols_done_q;
	logic [3:0]  held_nibble_q;
	logic        nibble_pending_q;

	// Per-item work registers
	state_t      state_q;
	logic [31:0] word_q;
	logic [2:0]  left_q;
	logic [1:0]  used_q;
	logic [12:0] x_q;
	logic [31:0] quo_q;
	logic [3:0]  s_q;
	logic [31:0] freq_q;
	logic [31:0] xm_q;
	result_t     res_q;
	result_t     out_q;
	logic        out_valid_q;

	// Divider hookup
	logic        div_start;
	logic        div_done;
	logic [31:0] div_quo;
	logic [12:0] div_rem;

	logic        in_take;
	logic        out_take;
	logic        out_free;
	logic [2:0]  left_clamp;
	logic [12:0] tf_eff;
	logic [4:0]  asz_eff;
	logic [4:0]  s_inc;
	logic [11:0] start_cur;
	logic [11:0] start_nxt;
	logic        step_on;
	logic [31:0] next_val;
	logic        renorm_on;
	logic [15:0] done_next;
	logic        last_sym;
	result_t     res_idle;
	result_t     res_dec;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign left_clamp = (bytes_left > 3'd4) ? 3'd4 : bytes_left;
	assign tf_eff     = (total_freq_q == 13'd0) ? 13'd1 : total_freq_q;
	assign asz_eff    = (alphabet_size_q == 5'd0) ? 5'd1 :
		(alphabet_size_q > 5'(MaxSymbols)) ? 5'(MaxSymbols) : alphabet_size_q;

	// Linear table scan: one candidate symbol per cycle
	assign s_inc     = {1'b0, s_q} + 5'd1;
	assign start_cur = cum_start(cum_low_q, cum_mid_q, cum_high_q, s_q);
	assign start_nxt = cum_start(cum_low_q, cum_mid_q, cum_high_q, s_inc[3:0]);
	assign step_on   = (s_inc < asz_eff) && (x_q >= {1'b0, start_nxt});
	assign next_val  = (s_inc < asz_eff) ? {20'd0, start_nxt} : {19'd0, tf_eff};

	// Renormalization shifts one byte per cycle
	assign renorm_on = (used_q < 2'd3) && ({1'b0, used_q} < left_q) &&
		(coder_state_q < StateBound);

	assign done_next = symbols_done_q + 16'd1;
	assign last_sym  = done_next >= symbol_count_q;

	assign div_start = in_take && (operation == OP_DECODE) &&
		(symbols_done_q < symbol_count_q);

	// Result of a start, or of a decode past the end
	// Result of a live decode, taken when renormalization ends
	always_comb begin
		res_idle = '0;
		if (operation == OP_START) begin
			res_idle.bytes_used = left_clamp;
			res_idle.finished   = (symbol_count_q == 16'd0);
		end else begin
			res_idle.finished = 1'b1;
		end
		res_dec            = '0;
		res_dec.symbol     = s_q;
		res_dec.bytes_used = {1'b0, used_q};
		res_dec.finished   = last_sym;
		if (nibble_pending_q) begin
			res_dec.packed_byte = {held_nibble_q, s_q};
			res_dec.byte_valid  = 1'b1;
		end else if (last_sym) begin
			res_dec.packed_byte = {s_q, 4'd0};
			res_dec.byte_valid  = 1'b1;
		end
	end

	rnd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (coder_state_q),
		.divisor   (tf_eff),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_freq_q    <= 13'd4096;
			alphabet_size_q <= 5'd16;
			cum_low_q       <= '0;
			cum_mid_q       <= '0;
			cum_high_q      <= '0;
			symbol_count_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TOTAL_FREQ:    total_freq_q    <= cfg_data[12:0];
				REG_ALPHABET_SIZE: alphabet_size_q <= cfg_data[4:0];
				REG_CUM_LOW:       cum_low_q       <= cfg_data;
				REG_CUM_MID:       cum_mid_q       <= cfg_data;
				REG_CUM_HIGH:      cum_high_q      <= cfg_data;
				REG_SYMBOL_COUNT:  symbol_count_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Sequencer and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			coder_state_q    <= '0;
			symbols_done_q   <= '0;
			held_nibble_q    <= '0;
			nibble_pending_q <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			// a new result replaces a taken one in the same cycle
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (operation == OP_START) begin
							coder_state_q    <= stream_word;
							symbols_done_q   <= '0;
							held_nibble_q    <= '0;
							nibble_pending_q <= 1'b0;
							state_q          <= ST_DONE;
						end else if (div_start) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (!step_on) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					coder_state_q <= freq_q * quo_q;
					state_q       <= ST_ADD;
				end
				ST_ADD: begin
					coder_state_q <= coder_state_q + xm_q;
					state_q       <= ST_RENORM;
				end
				ST_RENORM: begin
					if (renorm_on) begin
						coder_state_q <= {coder_state_q[23:0], word_q[31:24]};
					end else begin
						symbols_done_q <= done_next;
						if (nibble_pending_q) begin
							nibble_pending_q <= 1'b0;
							held_nibble_q    <= '0;
						end else if (!last_sym) begin
							held_nibble_q    <= s_q;
							nibble_pending_q <= 1'b1;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Work and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				word_q <= stream_word;
				left_q <= left_clamp;
				used_q <= '0;
				res_q  <= res_idle;
			end
			ST_DIV: begin
				x_q   <= div_rem;
				quo_q <= div_quo;
				s_q   <= '0;
			end
			ST_SEARCH: begin
				if (step_on) begin
					s_q <= s_inc[3:0];
				end else begin
					freq_q <= next_val - {20'd0, start_cur};
					xm_q   <= {19'd0, x_q} - {20'd0, start_cur};
				end
			end
			ST_RENORM: begin
				if (renorm_on) begin
					word_q <= {word_q[23:0], 8'd0};
					used_q <= used_q + 2'd1;
				end else begin
					res_q <= res_dec;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign symbol      = out_q.symbol;
	assign bytes_used  = out_q.bytes_used;
	assign packed_byte = out_q.packed_byte;
	assign byte_valid  = out_q.byte_valid;
	assign finished    = out_q.finished;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the rANS nibble decoder unit: scoreboard, drivers, stimulus.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rnd_pkg::*;

	localparam int unsigned ItemTarget   = 1400;  // live transactions before stopping
	localparam int unsigned QuietTail    = 150;   // last stretch runs with no idling
	localparam int unsigned StallLimit   = 3000;  // cycles without any handshake
	localparam int unsigned LongHold     = 400;   // one long receiver hold-off
	localparam int unsigned SettleCycles = 64;    // wait after the final drain before the verdict
	localparam int unsigned NumRegs      = 6;

	// indexes past the register list; writes there must be ignored
	localparam logic [2:0] REG_NONE_LO = 3'd6;
	localparam logic [2:0] REG_NONE_HI = 3'd7;

	// Tracks config and coder state, predicts one result per input transaction and
	// checks output transactions against them in order.
	class decode_checker;
		logic [12:0]  freq_total;
		logic [4:0]   n_symbols;
		logic [179:0] cum_starts;   // symbol s start in bits (s-1)*12 +: 12
		logic [15:0]  brick_len;
		logic [31:0]  x_state;
		logic [15:0]  decoded_cnt;
		logic [3:0]   hi_nibble;
		logic         half_pair;
		bit           last_live;
		int unsigned  errors;
		result_t      expected_results[$];

		function new();
			freq_total  = 13'd4096;
			n_symbols   = 5'd16;
			cum_starts  = '0;
			brick_len   = '0;
			x_state     = '0;
			decoded_cnt = '0;
			hi_nibble   = '0;
			half_pair   = 1'b0;
			last_live   = 1'b0;
			errors      = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [59:0] val);
			case (idx)
				REG_TOTAL_FREQ: begin
					freq_total = val[12:0];
				end
				REG_ALPHABET_SIZE: begin
					n_symbols = val[4:0];
				end
				REG_CUM_LOW: begin
					cum_starts[59:0] = val;
				end
				REG_CUM_MID: begin
					cum_starts[119:60] = val;
				end
				REG_CUM_HIGH: begin
					cum_starts[179:120] = val;
				end
				REG_SYMBOL_COUNT: begin
					brick_len = val[15:0];
				end
				default: ;
			endcase
		endfunction

		function logic [31:0] sym_start(int unsigned s);
			if (s == 0 || s > 15) return 32'd0;
			return 32'(cum_starts[(s - 1) * 12 +: 12]);
		endfunction

		function result_t note_item(logic op, logic [31:0] word, logic [2:0] left);
			result_t     r;
			int unsigned avail, used, asz, s;
			logic [31:0] tf, rem, quo, lo, hi;
			r = '0;
			avail = (left > 3'd4) ? 4 : left;
			used = 0;
			last_live = 1'b0;
			if (op == OP_START) begin
				x_state     = word;
				decoded_cnt = '0;
				hi_nibble   = '0;
				half_pair   = 1'b0;
				used        = avail;
				last_live   = 1'b1;
			end else if (decoded_cnt < brick_len) begin
				last_live = 1'b1;
				tf  = (freq_total == 0) ? 32'd1 : 32'(freq_total);
				asz = (n_symbols == 0) ? 1 : (n_symbols > MaxSymbols) ? MaxSymbols : n_symbols;
				rem = x_state % tf;
				quo = x_state / tf;
				s = 0;
				while (s + 1 < asz && rem >= sym_start(s + 1)) s++;
				lo = sym_start(s);
				hi = (s + 1 < asz) ? sym_start(s + 1) : tf;
				// all mod 2^32, so unsorted tables just wrap
				x_state = (hi - lo) * quo + (rem - lo);
				while (used < 3 && used < avail && x_state < StateBound) begin
					x_state = {x_state[23:0], word[31 - 8 * used -: 8]};
					used++;
				end
				r.symbol = 4'(s);
				decoded_cnt = decoded_cnt + 16'd1;
				if (half_pair) begin
					r.packed_byte = {hi_nibble, 4'(s)};
					r.byte_valid  = 1'b1;
					half_pair     = 1'b0;
					hi_nibble     = '0;
				end else if (decoded_cnt >= brick_len) begin
					r.packed_byte = {4'(s), 4'd0};
					r.byte_valid  = 1'b1;
				end else begin
					hi_nibble = 4'(s);
					half_pair = 1'b1;
				end
			end
			r.bytes_used = 3'(used);
			r.finished   = (decoded_cnt >= brick_len);
			expected_results = {expected_results, r};
			return r;
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				$error("unexpected result: symbol %0d bytes_used %0d packed_byte %02h",
					got.symbol, got.bytes_used, got.packed_byte);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.symbol !== want.symbol) begin
				$error("symbol: expected %0d, actual %0d", want.symbol, got.symbol);
				errors++;
			end
			if (got.bytes_used !== want.bytes_used) begin
				$error("bytes_used: expected %0d, actual %0d", want.bytes_used, got.bytes_used);
				errors++;
			end
			if (got.packed_byte !== want.packed_byte) begin
				$error("packed_byte: expected %02h, actual %02h", want.packed_byte, got.packed_byte);
				errors++;
			end
			if (got.byte_valid !== want.byte_valid) begin
				$error("byte_valid: expected %0d, actual %0d", want.byte_valid, got.byte_valid);
				errors++;
			end
			if (got.finished !== want.finished) begin
				$error("finished: expected %0d, actual %0d", want.finished, got.finished);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [59:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [31:0] stream_word;
	logic [2:0]  bytes_left;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  symbol;
	logic [2:0]  bytes_used;
	logic [7:0]  packed_byte;
	logic        byte_valid;
	logic        finished;

	decode_checker chk;
	logic [59:0]   reg_img [NumRegs];   // values the next program_regs call writes
	bit            idle_on     = 1'b1;  // random gaps and stalls allowed
	bit            hold_req    = 1'b0;  // asks the receiver for one long hold-off
	int unsigned   gap_pct     = 0;     // sender gap chance per transaction
	int unsigned   stall_pct   = 0;     // receiver stall chance per cycle
	int unsigned   live_items  = 0;
	int unsigned   idle_cycles = 0;

	rans_nibble_decoder_unit uut (.*);

	always #5ns clk = ~clk;

	function automatic logic [59:0] rand60();
		return 60'({$urandom, $urandom});
	endfunction

	// Well-formed cumulative table: strictly rising starts below tf, every symbol gets
	// at least one slot. Slots past the alphabet keep random junk.
	function automatic void make_table(int unsigned tf, int unsigned asz);
		int unsigned  w[16];
		int unsigned  wsum, acc, spare;
		logic [179:0] tab;
		tab = 180'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		wsum = 0;
		for (int i = 0; i < 16; i++) begin
			w[i] = $urandom_range(1, 1 << $urandom_range(0, 8));
			if (i < asz) wsum += w[i];
		end
		spare = tf - asz;
		acc = 0;
		for (int s = 1; s < asz; s++) begin
			acc += w[s - 1];
			tab[(s - 1) * 12 +: 12] = 12'(s + spare * acc / wsum);
		end
		reg_img[REG_CUM_LOW]  = tab[59:0];
		reg_img[REG_CUM_MID]  = tab[119:60];
		reg_img[REG_CUM_HIGH] = tab[179:120];
	endfunction

	// One input transaction; in_valid stays up for a back-to-back follower.
	task automatic send_item(input logic op, input logic [31:0] word, input logic [2:0] left,
		output result_t want);
		if (idle_on && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		stream_word <= word;
		bytes_left  <= left;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		want = chk.note_item(op, word, left);
		if (chk.last_live) live_items++;
	endtask

	// Sender pause until every expected result is back and the unit is idle.
	task automatic drain();
		in_valid <= 1'b0;
		while (chk.expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [59:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		chk.write_reg(idx, val);
	endtask

	task automatic program_regs(input bit [NumRegs-1:0] mask);
		drain();
		for (int i = 0; i < NumRegs; i++) begin
			if (mask[i]) write_reg(3'(i), reg_img[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// One brick: either a consistent stream under a sane model, or noise with random
	// registers, random operations and out-of-range bytes_left.
	task automatic run_brick(input bit clean, input bit with_hold);
		int unsigned tf, asz, cnt, rem, n_dec, cut;
		logic [31:0] word;
		logic [2:0]  left;
		result_t     want;
		if (clean) begin
			asz = $urandom_range(1, MaxSymbols);
			case ($urandom_range(9))
				0: tf = 4096;
				1: tf = asz;
				default: tf = $urandom_range(16, 4096);
			endcase
			if (tf < asz) tf = asz;
			case ($urandom_range(19))
				0: cnt = 0;
				1, 2: cnt = $urandom_range(40, 120);
				default: cnt = $urandom_range(1, 24);
			endcase
			if (with_hold && cnt < 12) cnt = 12;
			make_table(tf, asz);
			reg_img[REG_TOTAL_FREQ]    = 60'(tf);
			reg_img[REG_ALPHABET_SIZE] = 60'(asz);
			reg_img[REG_SYMBOL_COUNT]  = 60'(cnt);
			program_regs('1);
			// receiver holds off while the brick keeps coming; unit must back up
			if (with_hold) hold_req = 1'b1;
			rem = $urandom_range(4, 3 * cnt + 8);
			word = $urandom;
			if (word < StateBound) word = word | StateBound;
			left = (rem > 4) ? 3'd4 : 3'(rem);
			send_item(OP_START, word, left, want);
			rem -= want.bytes_used;
			n_dec = cnt + $urandom_range(0, 2);
			cut = (cnt > 4 && $urandom_range(7) == 0) ? $urandom_range(1, cnt - 1) : 0;
			for (int i = 1; i <= n_dec; i++) begin
				left = (rem > 4) ? 3'd4 : 3'(rem);
				send_item(OP_DECODE, $urandom, left, want);
				rem -= want.bytes_used;
				if (i == cut) begin
					// count lowered mid-brick; a held nibble is dropped
					reg_img[REG_SYMBOL_COUNT] = 60'($urandom_range(0, cnt));
					program_regs(6'b100000);
				end
			end
		end else begin
			for (int i = 0; i < NumRegs; i++) reg_img[i] = rand60();
			reg_img[REG_SYMBOL_COUNT][15:0] = 16'($urandom_range(0, 20));
			program_regs(6'($urandom_range(1, 63)));
			n_dec = $urandom_range(3, 20);
			for (int i = 0; i < n_dec; i++) begin
				send_item((i == 0 || $urandom_range(9) == 0) ? OP_START : OP_DECODE, $urandom,
					3'($urandom_range(0, 7)), want);
			end
		end
	endtask

	// Receiver: random stall bursts, plus the one long hold-off on request.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LongHold) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Output transactions are checked as they happen; the watchdog counts cycles in
	// which no channel completes a transaction.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			chk.check_result({symbol, bytes_used, packed_byte, byte_valid, finished});
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= StallLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		result_t     want;
		int unsigned bricks;
		chk = new();
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		operation   <= OP_START;
		stream_word <= '0;
		bytes_left  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct   = 20;
		stall_pct = 5;

		// reset config has a zero symbol count: decode past the end, then an empty start
		send_item(OP_DECODE, $urandom, 3'd4, want);
		send_item(OP_START, 32'h0000_0000, 3'd0, want);

		// full alphabet, three symbols so the last one is padded; start with bytes_left > 4
		make_table(4096, MaxSymbols);
		reg_img[REG_TOTAL_FREQ]    = 60'd4096;
		reg_img[REG_ALPHABET_SIZE] = 60'(MaxSymbols);
		reg_img[REG_SYMBOL_COUNT]  = 60'd3;
		program_regs('1);
		send_item(OP_START, 32'hFFFF_FFFF, 3'd7, want);
		repeat (3) send_item(OP_DECODE, $urandom, 3'd4, want);
		send_item(OP_DECODE, 32'hFFFF_FFFF, 3'd4, want);

		// short start, then decodes with a nearly empty stream
		send_item(OP_START, 32'h0080_0000, 3'd2, want);
		send_item(OP_DECODE, $urandom, 3'd1, want);
		send_item(OP_DECODE, $urandom, 3'd0, want);
		send_item(OP_DECODE, $urandom, 3'd3, want);

		// zero total acts as one, zero alphabet as one symbol
		reg_img[REG_TOTAL_FREQ]    = 60'd0;
		reg_img[REG_ALPHABET_SIZE] = 60'd0;
		reg_img[REG_CUM_LOW]       = rand60();
		reg_img[REG_CUM_MID]       = rand60();
		reg_img[REG_CUM_HIGH]      = rand60();
		reg_img[REG_SYMBOL_COUNT]  = 60'd2;
		program_regs('1);
		send_item(OP_START, 32'd1, 3'd4, want);
		repeat (2) send_item(OP_DECODE, $urandom, 3'd4, want);

		// widest total, oversized alphabet, unsorted tables, largest count
		reg_img[REG_TOTAL_FREQ]    = 60'd8191;
		reg_img[REG_ALPHABET_SIZE] = 60'd31;
		reg_img[REG_CUM_LOW]       = rand60();
		reg_img[REG_CUM_MID]       = rand60();
		reg_img[REG_CUM_HIGH]      = rand60();
		reg_img[REG_SYMBOL_COUNT]  = 60'd65535;
		program_regs('1);
		send_item(OP_START, $urandom, 3'd4, want);
		repeat (5) send_item(OP_DECODE, $urandom, 3'($urandom_range(5, 7)), want);

		// count lowered while a nibble is held: the nibble never comes out
		make_table(4096, MaxSymbols);
		reg_img[REG_TOTAL_FREQ]    = 60'd4096;
		reg_img[REG_ALPHABET_SIZE] = 60'(MaxSymbols);
		reg_img[REG_SYMBOL_COUNT]  = 60'd5;
		program_regs('1);
		send_item(OP_START, $urandom | StateBound, 3'd4, want);
		repeat (3) send_item(OP_DECODE, $urandom, 3'd4, want);
		reg_img[REG_SYMBOL_COUNT] = 60'd2;
		program_regs(6'b100000);
		send_item(OP_DECODE, $urandom, 3'd4, want);

		// writes past the register list change nothing
		drain();
		write_reg(REG_NONE_LO, rand60());
		write_reg(REG_NONE_HI, rand60());
		cfg_valid <= 1'b0;

		// random bricks; the third one, if clean, carries the long receiver hold-off
		bricks = 0;
		while (live_items < ItemTarget) begin
			if (live_items + QuietTail >= ItemTarget) idle_on = 1'b0;
			gap_pct   = 25 * $urandom_range(0, 2);
			stall_pct = 4 * $urandom_range(0, 2);
			run_brick($urandom_range(4) != 0, bricks == 2);
			bricks++;
		end

		drain();
		repeat (SettleCycles) @(posedge clk);
		if (chk.errors == 0 && chk.expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: rans_nibble_decoder_unit.f
hdl/rnd_pkg.sv
hdl/rnd_div.sv
hdl/rans_nibble_decoder_unit.sv
tb/testbench.sv
